// File: hdl/fst_pkg.sv
// Shared types and constants for the flow sequence tracker.
package fst_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_THR = 1'd1;

    localparam logic [15:0] GAP_THR_RST  = 16'd2;
    localparam logic [7:0]  FRAG_THR_RST = 8'd50;
    localparam logic [7:0]  CNT_MAX      = 8'hFF;

    typedef struct packed {
        logic [31:0] dst_addr;
        logic [15:0] dst_port_num;
        logic [15:0] stream_id;
        logic [31:0] seq_in;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic        inserted;
        logic        table_full;
        logic        backward_gap;
        logic        switchover;
        logic [31:0] tracked_seq;
        logic [3:0]  entry_slot;
    } t_out_word;

    // flow key as stored in the table
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] stream;
    } t_key;

    // per-flow sequence state
    typedef struct packed {
        logic [31:0] cur;
        logic [31:0] pend;
        logic [7:0]  cnt;
    } t_ent;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // capture input word, clear scan index
        logic rd;        // read both tables at scan index
        logic step;      // advance scan index
        logic upd_wr;    // write back updated state, load hit result
        logic ins_wr;    // append new entry, load insert result
        logic full_res;  // load table-full result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;     // read key equals captured key
        logic last;      // scan index is the last used entry
        logic empty;     // no entries in use
        logic tbl_full;  // every entry in use
        logic out_free;  // output register can take a word this cycle
    } t_sts;

endpackage

// File: hdl/fst_ctrl.sv
// Sequencer for lookup, update and insert of one word at a time.
module fst_ctrl
    import fst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CMP  = 5'b00100,
        S_UPD  = 5'b01000,
        S_MISS = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.empty ? S_MISS : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (i_sts.match) begin
                    n_state = S_UPD;
                end else if (i_sts.last) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.upd_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MISS: begin
                if (i_sts.out_free) begin
                    o_cmd.ins_wr   = !i_sts.tbl_full;
                    o_cmd.full_res = i_sts.tbl_full;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: hdl/fst_dpath.sv
// Flow tables, scan index, sequence update logic and output register.
module fst_dpath
    import fst_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  t_in_word              i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    t_key r_key_mem [ENTRIES];
    t_ent r_ent_mem [ENTRIES];

    t_key          r_key_q;
    t_ent          r_ent_q;
    t_in_word      r_in;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_used;
    logic [15:0]   r_gap_thr;
    logic [7:0]    r_frag_thr;
    logic          r_out_valid;
    t_out_word     r_out;

    t_key          cur_key;
    logic [31:0]   gap;
    logic          lower;
    logic          bgap;
    logic [7:0]    cnt_inc;
    logic          swv;
    t_ent          upd_ent;
    t_ent          new_ent;
    logic [IW-1:0] ins_idx;
    logic [IW+3:0] idx_ext;
    logic [IW+3:0] ins_ext;
    logic          out_free;

    assign cur_key = '{addr: r_in.dst_addr, port: r_in.dst_port_num, stream: r_in.stream_id};
    assign ins_idx = r_used[IW-1:0];
    assign idx_ext = {4'b0000, r_idx};
    assign ins_ext = {4'b0000, ins_idx};
    assign out_free = !r_out_valid || i_out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_thr  <= GAP_THR_RST;
            r_frag_thr <= FRAG_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAP_THR:  r_gap_thr  <= i_cfg_data;
                CFG_FRAG_THR: r_frag_thr <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequence update for a hit entry
    always_comb begin
        gap     = r_ent_q.cur - r_in.seq_in;
        lower   = r_ent_q.cur > r_in.seq_in;
        bgap    = lower && (gap >= {16'h0000, r_gap_thr});
        cnt_inc = (r_ent_q.cnt == CNT_MAX) ? r_ent_q.cnt : r_ent_q.cnt + 8'd1;
        swv     = bgap && (cnt_inc > r_frag_thr);
        if (!lower) begin
            upd_ent = '{cur: r_in.seq_in, pend: r_ent_q.pend, cnt: r_ent_q.cnt};
        end else if (swv) begin
            upd_ent = '{cur: r_ent_q.pend, pend: 32'h0, cnt: 8'h00};
        end else if (bgap) begin
            upd_ent = '{cur: r_ent_q.cur, pend: r_in.seq_in, cnt: cnt_inc};
        end else begin
            upd_ent = '{cur: r_ent_q.cur, pend: 32'h0, cnt: 8'h00};
        end
        new_ent = '{cur: r_in.seq_in, pend: 32'h0, cnt: 8'h00};
    end

    // tables: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            r_key_mem[ins_idx] <= cur_key;
        end
        if (i_cmd.rd) begin
            r_key_q <= r_key_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            r_ent_mem[ins_idx] <= new_ent;
        end else if (i_cmd.upd_wr) begin
            r_ent_mem[r_idx] <= upd_ent;
        end
        if (i_cmd.rd) begin
            r_ent_q <= r_ent_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_used <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.ins_wr) begin
                r_used <= r_used + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd_wr || i_cmd.ins_wr || i_cmd.full_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_wr) begin
            r_out <= '{hit: 1'b1, inserted: 1'b0, table_full: 1'b0,
                       backward_gap: bgap, switchover: swv,
                       tracked_seq: upd_ent.cur, entry_slot: idx_ext[3:0]};
        end else if (i_cmd.ins_wr) begin
            r_out <= '{hit: 1'b0, inserted: 1'b1, table_full: 1'b0,
                       backward_gap: 1'b0, switchover: 1'b0,
                       tracked_seq: r_in.seq_in, entry_slot: ins_ext[3:0]};
        end else if (i_cmd.full_res) begin
            r_out <= '{hit: 1'b0, inserted: 1'b0, table_full: 1'b1,
                       backward_gap: 1'b0, switchover: 1'b0,
                       tracked_seq: 32'h0, entry_slot: 4'h0};
        end
    end

    assign o_sts.match    = (r_key_q == cur_key);
    assign o_sts.last     = ({1'b0, r_idx} + 1'b1) == r_used;
    assign o_sts.empty    = (r_used == '0);
    assign o_sts.tbl_full = (r_used == FULL_CNT);
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/flow_sequence_tracker_top.sv
// Flow sequence tracker: flow table lookup/insert with per-flow sequence gap tracking.
//
// Input channel (i_in_valid / o_in_ready, i_in_data): one word per packet,
// carrying the flow key (address, port, stream id) and the sequence number.
// Output channel (o_out_valid / i_out_ready, o_out_data): one result word per
// input word, in order: hit / inserted / table_full flags, gap and switchover
// flags, the entry's current sequence number and its slot.
// Config port (i_cfg_we, i_cfg_idx, i_cfg_data): index 0 gap threshold,
// index 1 fragment threshold; write only while idle.
// Timing: keys are scanned one table entry at a time (read, compare)
// through a single-read-port table. A hit loads its result from the update state,
// a miss from the miss state, each once the output register can take it. Ready
// returns the cycle after the load.
// Stalls: the output register holds a result while the receiver stalls; the
// block accepts and scans the next word meanwhile and waits only to load.
// Reset: table emptied (fill count cleared), thresholds back to 2 and 50,
// output valid dropped. No clearing pass is needed.
module flow_sequence_tracker_top
    import fst_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    fst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fst_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // exactly one outcome per result word
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot({o_out_data.hit, o_out_data.inserted, o_out_data.table_full}))
        else $error("result word carries not exactly one outcome");

    // gap and switchover only on a hit, switchover only with a gap
    a_gap_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.backward_gap || o_out_data.switchover)
            |-> o_out_data.hit && (o_out_data.backward_gap || !o_out_data.switchover))
        else $error("gap flags on a non-hit result or switchover without gap");

    // one word at a time: no accept in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accept");

    // a result is only loaded by a finished lookup, never out of thin air
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a word in progress");

endmodule
